// ===== hdl/uhp_pkg.sv =====
`default_nettype none
package uhp_pkg;

  localparam int PACKET_BYTES   = 24;
  localparam int SESSION_OFFSET = 8;
  localparam int SESSION_BYTES  = 16;
  localparam int IDX_W          = $clog2(PACKET_BYTES + 1);
  localparam int SID_IDX_W      = $clog2(SESSION_BYTES);

  localparam logic [31:0] MAGIC_WORD   = 32'd1296388168;
  localparam logic [7:0]  VERSION_CODE = 8'd1;
  localparam logic [7:0]  PROBE_CODE   = 8'd1;
  localparam logic [7:0]  ACK_CODE     = 8'd2;

  localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;
  localparam logic [15:0] INTERVAL_RESET = 16'd200;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_SID_HIGH = 2'd2,
    REG_SID_LOW  = 2'd3
  } reg_idx_t;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PROBING   = 3'd1,
    PH_GOT_PROBE = 3'd2,
    PH_CONFIRMED = 3'd3,
    PH_FAILED    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_PROBE     = 3'd1,
    ACT_ACK       = 3'd2,
    ACT_CONFIRMED = 3'd3,
    ACT_FAILED    = 3'd4
  } action_t;

  // classified work handed from the front to the back
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_START    = 3'd2,
    CMD_PROBE_RX = 3'd3,
    CMD_ACK_RX   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [15:0] probe_interval_ticks;
    logic [63:0] session_id_high;
    logic [63:0] session_id_low;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/uhp_if.sv =====
`default_nettype none
interface uhp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output mode, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input last_byte,
                  output ready);
endinterface

interface uhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] rtt_ticks;
  logic [2:0]  phase;

  modport source (output valid, output action, output rtt_ticks, output phase,
                  input ready);
  modport sink   (input valid, input action, input rtt_ticks, input phase,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/udp_hole_punch_controller_core.sv =====
// channel   dir   handshake       payload
// in_ch     in    valid / ready   mode[1:0], data_byte[7:0], last_byte
// out_ch    out   valid / ready   action[2:0], rtt_ticks[15:0], phase[2:0]
// cfg_*     in    cfg_we only     cfg_index[1:0], cfg_wdata[63:0]
//
// One word in and one word out per cycle while out_ch.ready holds; words go through
// the front parser and queue write, then the back update into the output register.
// A two-entry queue between parser and attempt controller lets each side stall alone.
// Sync reset on rst_n restores defaults to all but the result word and queue memory.
// in_ch.ready drops only while the queue is full behind a stalled out_ch.
`default_nettype none
module udp_hole_punch_controller_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  uhp_in_if.sink                                 in_ch,
  uhp_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [uhp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [uhp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import uhp_pkg::*;

  cfg_t cfg_r;
  logic push, pop, q_full, q_not_empty;
  cmd_t push_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks        <= TIMEOUT_RESET;
      cfg_r.probe_interval_ticks <= INTERVAL_RESET;
      cfg_r.session_id_high      <= '0;
      cfg_r.session_id_low       <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TIMEOUT:  cfg_r.timeout_ticks        <= cfg_wdata[31:0];
        REG_INTERVAL: cfg_r.probe_interval_ticks <= cfg_wdata[15:0];
        REG_SID_HIGH: cfg_r.session_id_high      <= cfg_wdata;
        REG_SID_LOW:  cfg_r.session_id_low       <= cfg_wdata;
        default:      cfg_r.session_id_low       <= cfg_r.session_id_low;
      endcase
    end
  end

  uhp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  uhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  uhp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_confirm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_CONFIRMED |-> out_ch.phase == PH_CONFIRMED)
    else $error("confirmed word without confirmed phase");

  a_fail_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_FAILED |-> out_ch.phase == PH_FAILED)
    else $error("failed word without failed phase");

  a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action == ACT_ACK |-> out_ch.phase == PH_GOT_PROBE)
    else $error("ack requested outside got-probe phase");

  a_rtt_only_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.action != ACT_CONFIRMED |-> out_ch.rtt_ticks == 16'd0)
    else $error("round trip reported without confirmation");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_not_empty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== hdl/uhp_front.sv =====
`default_nettype none
module uhp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  uhp_in_if.sink             in_ch,
  input  wire uhp_pkg::cfg_t cfg,
  input  wire logic          q_full,
  output      logic          push,
  output      uhp_pkg::cmd_t push_cmd
);
  import uhp_pkg::*;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic             packet_good_r, packet_good_nxt;
  logic [7:0]       packet_kind_r, packet_kind_nxt;

  logic [127:0]         sid;
  logic [1:0]           magic_sel;
  logic [IDX_W-1:0]     sid_pos;
  logic [SID_IDX_W-1:0] sid_sel;
  logic [7:0]           want;
  logic                 want_vld;
  logic                 in_range;
  logic                 accept;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !q_full;
  assign push         = accept;
  assign sid          = {cfg.session_id_high, cfg.session_id_low};
  assign magic_sel    = 2'd3 - byte_index_r[1:0];
  assign sid_pos      = byte_index_r - IDX_W'(SESSION_OFFSET);
  assign sid_sel      = SID_IDX_W'(SESSION_BYTES - 1) - sid_pos[SID_IDX_W-1:0];
  assign in_range     = byte_index_r < IDX_W'(PACKET_BYTES);

  // expected byte at the current position; reserved and type bytes carry none
  always_comb begin
    want     = '0;
    want_vld = 1'b0;
    if (byte_index_r < IDX_W'(4)) begin
      want     = MAGIC_WORD[{magic_sel, 3'b000} +: 8];
      want_vld = 1'b1;
    end else if (byte_index_r == IDX_W'(5)) begin
      want     = VERSION_CODE;
      want_vld = 1'b1;
    end else if (byte_index_r >= IDX_W'(SESSION_OFFSET) &&
                 byte_index_r < IDX_W'(SESSION_OFFSET + SESSION_BYTES)) begin
      want     = sid[{sid_sel, 3'b000} +: 8];
      want_vld = 1'b1;
    end
  end

  always_comb begin
    byte_index_nxt  = byte_index_r;
    packet_good_nxt = packet_good_r;
    packet_kind_nxt = packet_kind_r;
    push_cmd        = CMD_NONE;
    if (accept) begin
      case (in_ch.mode)
        MODE_TICK:  push_cmd = CMD_TICK;
        MODE_START: push_cmd = CMD_START;
        MODE_BYTE: begin
          if (in_range) begin
            if (byte_index_r == IDX_W'(4)) begin
              packet_kind_nxt = in_ch.data_byte;
              if (in_ch.data_byte != PROBE_CODE && in_ch.data_byte != ACK_CODE) begin
                packet_good_nxt = 1'b0;
              end
            end else if (want_vld && want != in_ch.data_byte) begin
              packet_good_nxt = 1'b0;
            end
            byte_index_nxt = byte_index_r + IDX_W'(1);
          end
          if (in_ch.last_byte) begin
            if (byte_index_nxt >= IDX_W'(PACKET_BYTES) && packet_good_nxt) begin
              if (packet_kind_nxt == PROBE_CODE) begin
                push_cmd = CMD_PROBE_RX;
              end else if (packet_kind_nxt == ACK_CODE) begin
                push_cmd = CMD_ACK_RX;
              end
            end
            // clear the parser after every packet end
            byte_index_nxt  = '0;
            packet_good_nxt = 1'b1;
            packet_kind_nxt = '0;
          end
        end
        default: push_cmd = CMD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= '0;
      packet_good_r <= 1'b1;
      packet_kind_r <= '0;
    end else begin
      byte_index_r  <= byte_index_nxt;
      packet_good_r <= packet_good_nxt;
      packet_kind_r <= packet_kind_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uhp_queue.sv =====
`default_nettype none
module uhp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire uhp_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output      logic          full,
  output      logic          not_empty,
  output      uhp_pkg::cmd_t head
);
  import uhp_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uhp_back.sv =====
`default_nettype none
module uhp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire uhp_pkg::cfg_t cfg,
  input  wire logic          q_not_empty,
  input  wire uhp_pkg::cmd_t q_head,
  output      logic          pop,
  uhp_out_if.source          out_ch
);
  import uhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [15:0] since_r, since_nxt;
  logic        out_valid_r;
  action_t     action_r, action_nxt;
  logic [15:0] rtt_r, rtt_nxt;

  logic [31:0] elapsed_inc;
  logic [15:0] since_inc;
  logic        active;

  assign pop         = q_not_empty && (!out_valid_r || out_ch.ready);
  assign active      = phase_r == PH_PROBING || phase_r == PH_GOT_PROBE;
  assign elapsed_inc = elapsed_r + 32'd1;
  assign since_inc   = (since_r == 16'hFFFF) ? since_r : since_r + 16'd1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.action    = action_r;
  assign out_ch.rtt_ticks = rtt_r;
  assign out_ch.phase     = phase_r;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    since_nxt   = since_r;
    action_nxt  = ACT_NONE;
    rtt_nxt     = '0;
    case (q_head)
      CMD_TICK: begin
        if (active) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= cfg.timeout_ticks) begin
            phase_nxt  = PH_FAILED;
            action_nxt = ACT_FAILED;
          end else if (since_inc >= cfg.probe_interval_ticks) begin
            since_nxt  = '0;
            action_nxt = ACT_PROBE;
          end else begin
            since_nxt = since_inc;
          end
        end
      end
      CMD_START: begin
        phase_nxt   = PH_PROBING;
        elapsed_nxt = '0;
        since_nxt   = '0;
        action_nxt  = ACT_PROBE;
      end
      CMD_PROBE_RX: begin
        if (active) begin
          action_nxt = ACT_ACK;
          phase_nxt  = PH_GOT_PROBE;
        end
      end
      CMD_ACK_RX: begin
        if (active) begin
          action_nxt = ACT_CONFIRMED;
          phase_nxt  = PH_CONFIRMED;
          rtt_nxt    = since_r;
        end
      end
      default: action_nxt = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        elapsed_r <= elapsed_nxt;
        since_r   <= since_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word; hold while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      action_r <= action_nxt;
      rtt_r    <= rtt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sim/uhp_punch_checker.sv =====
`timescale 1ns / 1ps
module uhp_punch_checker
  import uhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            out_action,
  input  logic [15:0]           out_rtt_ticks,
  input  logic [2:0]            out_phase,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_words
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    action_t     action;
    logic [15:0] rtt;
    phase_t      phase;
  } punch_word_t;

  punch_word_t expected_words[$];
  int          reported;

  // configuration shadow
  logic [31:0] timeout_reg;
  logic [15:0] interval_reg;
  logic [63:0] sid_high_reg;
  logic [63:0] sid_low_reg;

  // attempt and parser state
  phase_t      att_phase;
  logic [31:0] elapsed;
  logic [15:0] since_probe;
  logic [4:0]  byte_idx;
  logic        pkt_good;
  logic [7:0]  pkt_kind;

  assign pending_words = expected_words.size();

  task automatic punch_predict(input logic [1:0] mode, input logic [7:0] data,
                               input logic last);
    punch_word_t r;
    logic        active;
    int          pos;
    logic [7:0]  want;
    logic        chk;
    r.action = ACT_NONE;
    r.rtt    = '0;
    active   = (att_phase == PH_PROBING) || (att_phase == PH_GOT_PROBE);
    case (mode)
      MODE_TICK: begin
        if (active) begin
          elapsed = elapsed + 32'd1;
          if (elapsed >= timeout_reg) begin
            att_phase = PH_FAILED;
            r.action  = ACT_FAILED;
          end else begin
            if (since_probe != 16'hFFFF) since_probe = since_probe + 16'd1;
            if (since_probe >= interval_reg) begin
              since_probe = '0;
              r.action    = ACT_PROBE;
            end
          end
        end
      end
      MODE_BYTE: begin
        pos = byte_idx;
        if (pos < PACKET_BYTES) begin
          if (pos == 4) begin
            pkt_kind = data;
            if (data != PROBE_CODE && data != ACK_CODE) pkt_good = 1'b0;
          end else begin
            chk = 1'b1;
            want = '0;
            if (pos < 4) want = MAGIC_WORD[8*(3-pos) +: 8];
            else if (pos == 5) want = VERSION_CODE;
            else if (pos >= SESSION_OFFSET && pos < SESSION_OFFSET + 8)
              want = sid_high_reg[8*(SESSION_OFFSET + 7 - pos) +: 8];
            else if (pos >= SESSION_OFFSET + 8 && pos < SESSION_OFFSET + SESSION_BYTES)
              want = sid_low_reg[8*(SESSION_OFFSET + 15 - pos) +: 8];
            else chk = 1'b0;
            if (chk && want != data) pkt_good = 1'b0;
          end
          byte_idx = 5'(pos + 1);
        end
        if (last) begin
          if (byte_idx >= PACKET_BYTES && pkt_good && active) begin
            if (pkt_kind == PROBE_CODE) begin
              r.action = ACT_ACK;
              if (att_phase == PH_PROBING) att_phase = PH_GOT_PROBE;
            end else if (pkt_kind == ACK_CODE) begin
              r.action  = ACT_CONFIRMED;
              r.rtt     = since_probe;
              att_phase = PH_CONFIRMED;
            end
          end
          byte_idx = '0;
          pkt_good = 1'b1;
          pkt_kind = '0;
        end
      end
      MODE_START: begin
        att_phase   = PH_PROBING;
        elapsed     = '0;
        since_probe = '0;
        r.action    = ACT_PROBE;
      end
      default: ;
    endcase
    r.phase = att_phase;
    expected_words.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    punch_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      timeout_reg  = TIMEOUT_RESET;
      interval_reg = INTERVAL_RESET;
      sid_high_reg = '0;
      sid_low_reg  = '0;
      att_phase    = PH_IDLE;
      elapsed      = '0;
      since_probe  = '0;
      byte_idx     = '0;
      pkt_good     = 1'b1;
      pkt_kind     = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:  timeout_reg  = cfg_wdata[31:0];
          REG_INTERVAL: interval_reg = cfg_wdata[15:0];
          REG_SID_HIGH: sid_high_reg = cfg_wdata;
          REG_SID_LOW:  sid_low_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) punch_predict(in_mode, in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t: unexpected word action %0d rtt %0d phase %0d", $realtime,
                     out_action, out_rtt_ticks, out_phase);
          end
        end else begin
          want = expected_words.pop_front();
          if (out_action !== want.action || out_rtt_ticks !== want.rtt ||
              out_phase !== want.phase) begin
            mismatch_count++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("%0t: expected action %0d rtt %0d phase %0d, got %0d %0d %0d",
                       $realtime, want.action, want.rtt, want.phase,
                       out_action, out_rtt_ticks, out_phase);
            end
          end
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    reported       = 0;
  end

endmodule

// ===== sim/tb_udp_hole_punch_controller_core.sv =====
`timescale 1ns / 1ps
module tb_udp_hole_punch_controller_core;
  import uhp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_WORDS = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  uhp_in_if  in_ch();
  uhp_out_if out_ch();

  int          idle_pct;
  int          stall_pct;
  int          words_sent;
  int          mismatch_total;
  int          words_pending;
  int          hold_left;
  logic        hold_go;
  logic        hold_done;
  logic [63:0] sid_high;
  logic [63:0] sid_low;

  udp_hole_punch_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  uhp_punch_checker punch_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_mode        (in_ch.mode),
    .in_data_byte   (in_ch.data_byte),
    .in_last_byte   (in_ch.last_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_action     (out_ch.action),
    .out_rtt_ticks  (out_ch.rtt_ticks),
    .out_phase      (out_ch.phase),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_total),
    .pending_words  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [7:0] data, input logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (mode != MODE_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  // bad_pos < 0 leaves the packet intact
  task automatic send_packet(input logic [7:0] kind, input int len, input int bad_pos);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i < 4) b = MAGIC_WORD[8*(3-i) +: 8];
      else if (i == 4) b = kind;
      else if (i == 5) b = VERSION_CODE;
      else if (i < SESSION_OFFSET || i >= PACKET_BYTES) b = 8'($urandom);
      else if (i < SESSION_OFFSET + 8) b = sid_high[8*(SESSION_OFFSET + 7 - i) +: 8];
      else b = sid_low[8*(SESSION_OFFSET + 15 - i) +: 8];
      if (i == bad_pos) b = b ^ 8'($urandom_range(255, 1));
      send_word(MODE_BYTE, b, i == len - 1);
    end
  endtask

  task automatic random_episode();
    int         pick;
    int         bad;
    logic [7:0] kind;
    pick = $urandom_range(99);
    kind = $urandom_range(1) ? ACK_CODE : PROBE_CODE;
    if (pick < 12) begin
      send_word(MODE_START, 8'($urandom), 1'($urandom));
    end else if (pick < 37) begin
      repeat ($urandom_range(1, 8)) send_word(MODE_TICK, 8'($urandom), 1'($urandom));
    end else if (pick < 72) begin
      send_packet(kind, ($urandom_range(4) == 0) ? PACKET_BYTES + $urandom_range(1, 4)
                                                 : PACKET_BYTES, -1);
    end else if (pick < 82) begin
      // skip the reserved bytes, they are never checked
      bad = $urandom_range(PACKET_BYTES - 3);
      if (bad >= 6) bad += 2;
      send_packet(kind, PACKET_BYTES, bad);
    end else if (pick < 90) begin
      send_packet(kind, $urandom_range(1, PACKET_BYTES - 1), -1);
    end else begin
      repeat ($urandom_range(1, 4))
        send_word(2'($urandom_range(3)), 8'($urandom), $urandom_range(4) == 0);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] tmo, input logic [15:0] ivl,
                           input logic [63:0] hi, input logic [63:0] lo,
                           input int snd_idle, input int rcv_stall, input int n);
    int start_count;
    drain();
    cfg_write(REG_TIMEOUT, 64'(tmo));
    cfg_write(REG_INTERVAL, 64'(ivl));
    cfg_write(REG_SID_HIGH, hi);
    cfg_write(REG_SID_LOW, lo);
    sid_high    = hi;
    sid_low     = lo;
    idle_pct    = snd_idle;
    stall_pct   = rcv_stall;
    start_count = words_sent;
    while (words_sent - start_count < n) random_episode();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_TICK;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_TIMEOUT;
    cfg_wdata       = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    words_sent      = 0;
    hold_go         = 1'b0;
    sid_high        = '0;
    sid_low         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, zero session id
    send_word(MODE_UNUSED, 8'hFF, 1'b1);
    send_word(MODE_TICK, 8'h00, 1'b0);
    send_word(MODE_START, 8'h00, 1'b0);
    send_word(MODE_TICK, 8'hA5, 1'b1);
    send_packet(PROBE_CODE, 3, -1);
    send_packet(PROBE_CODE, PACKET_BYTES, -1);
    send_packet(ACK_CODE, PACKET_BYTES + 2, -1);
    send_word(MODE_UNUSED, 8'h5A, 1'b0);
    begin : default_random
      int start_count;
      start_count = words_sent;
      while (words_sent - start_count < 60) random_episode();
    end

    run_phase(32'd12, 16'd3, {$urandom, $urandom}, {$urandom, $urandom}, 61, 0, 110);
    // zero timeout and zero interval
    run_phase(32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 61, 60);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 35, 35, 100);
    run_phase(32'd25, 16'd1, {$urandom, $urandom}, {$urandom, $urandom}, 0, 61, 140);
    run_phase(32'd300, 16'd7, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 70);
    drain();
    // hold off the result side while the sender keeps offering words
    hold_go = 1'b1;
    begin : tail_random
      int start_count;
      start_count = words_sent;
      while (words_sent - start_count < 30) random_episode();
    end

    drain();
    repeat (SETTLE_WORDS) @(negedge clk);
    if (mismatch_total == 0 && words_pending == 0) begin
      $display("udp_hole_punch_controller_core: match");
    end else begin
      $display("udp_hole_punch_controller_core: mismatch");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("udp_hole_punch_controller_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/uhp_pkg.sv
hdl/uhp_if.sv
hdl/uhp_front.sv
hdl/uhp_queue.sv
hdl/uhp_back.sv
hdl/udp_hole_punch_controller_core.sv
sim/uhp_punch_checker.sv
sim/tb_udp_hole_punch_controller_core.sv
